// ===== rtl/prpd_pkg.sv =====
package prpd_pkg;

    // Run header detection
    localparam logic [7:0] RUN_MARK   = 8'hC0;
    localparam logic [7:0] COUNT_MASK = 8'h3F;

    // Register field widths
    localparam int unsigned LEN_BITS   = 13;
    localparam int unsigned NPL_BITS   = 3;
    localparam int unsigned PITCH_BITS = 15;
    localparam int unsigned RUN_BITS   = 6;

    // Configuration port
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = PITCH_BITS;

    typedef logic [CFG_IDX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_BYTES_PER_LINE = 3'd0;
    localparam cfg_index_t CFG_NUM_PLANES     = 3'd1;
    localparam cfg_index_t CFG_IMAGE_HEIGHT   = 3'd2;
    localparam cfg_index_t CFG_IMAGE_WIDTH    = 3'd3;
    localparam cfg_index_t CFG_ROW_PITCH      = 3'd4;

    // Register reset values
    localparam logic [LEN_BITS-1:0]   RST_BYTES_PER_LINE = 13'd320;
    localparam logic [NPL_BITS-1:0]   RST_NUM_PLANES     = 3'd1;
    localparam logic [LEN_BITS-1:0]   RST_IMAGE_HEIGHT   = 13'd200;
    localparam logic [LEN_BITS-1:0]   RST_IMAGE_WIDTH    = 13'd320;
    localparam logic [PITCH_BITS-1:0] RST_ROW_PITCH      = 15'd320;

    // Register file contents as seen by the decoder
    typedef struct packed {
        logic [LEN_BITS-1:0]   bytes_per_line;
        logic [NPL_BITS-1:0]   num_planes;
        logic [LEN_BITS-1:0]   image_height;
        logic [LEN_BITS-1:0]   image_width;
        logic [PITCH_BITS-1:0] row_pitch;
    } cfg_t;

endpackage

// ===== rtl/prpd_cfg_regs.sv =====
module prpd_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  prpd_pkg::cfg_index_t            wr_index,
    input  logic [prpd_pkg::CFG_DATA_BITS-1:0] wr_data,
    output prpd_pkg::cfg_t                  cfg
);
    import prpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_BYTES_PER_LINE: cfg_next.bytes_per_line = wr_data[LEN_BITS-1:0];
                CFG_NUM_PLANES:     cfg_next.num_planes     = wr_data[NPL_BITS-1:0];
                CFG_IMAGE_HEIGHT:   cfg_next.image_height   = wr_data[LEN_BITS-1:0];
                CFG_IMAGE_WIDTH:    cfg_next.image_width    = wr_data[LEN_BITS-1:0];
                CFG_ROW_PITCH:      cfg_next.row_pitch      = wr_data[PITCH_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_line <= RST_BYTES_PER_LINE;
            cfg_reg.num_planes     <= RST_NUM_PLANES;
            cfg_reg.image_height   <= RST_IMAGE_HEIGHT;
            cfg_reg.image_width    <= RST_IMAGE_WIDTH;
            cfg_reg.row_pitch      <= RST_ROW_PITCH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pcx_rle_plane_decoder.sv =====
// PCX 8-bit run-length plane decoder. Compressed bytes enter one item at a
// time; a byte with both top bits set loads a run count (low six bits) and
// the following byte is written that many times, any other byte is written
// once. Each decoded byte leaves with its frame address (stepping by the
// plane count), an in_image flag for padding past the visible width, a
// last_of_run flag on the final byte of an input, and image_done on the byte
// that completes the last line; after that all input is swallowed until
// reset. The single shared address adder produces one pixel address per cycle
// while the output is not stalled, and at the end of a plane scan does the
// row base and scan start updates in two further steps. The input is stalled
// for the whole time an item is in work. Registers may be written only while
// the decoder is idle.
module pcx_rle_plane_decoder
#(
    parameter int unsigned ADDR_BITS  = 20,
    parameter int unsigned MAX_PLANES = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // compressed byte channel
    input  logic                               byte_valid,
    output logic                               byte_stall,
    input  logic [7:0]                         data_byte,
    // decoded pixel channel
    output logic                               pixel_valid,
    input  logic                               pixel_stall,
    output logic [7:0]                         pixel_value,
    output logic [19:0]                        pixel_addr,
    output logic                               in_image,
    output logic                               last_of_run,
    output logic                               image_done,
    // register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  prpd_pkg::cfg_index_t               cfg_index,
    input  logic [prpd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import prpd_pkg::*;

    localparam int unsigned PW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int unsigned CW  = PW + 1;
    localparam int unsigned COLW = LEN_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_ROW,
        S_ADDR
    } state_t;

    cfg_t cfg;

    state_t                state_reg;
    logic                  run_pending_reg;
    logic [RUN_BITS-1:0]   run_length_reg;
    logic [RUN_BITS-1:0]   remain_reg;
    logic [7:0]            value_reg;
    logic [COLW-1:0]       col_reg;
    logic [PW-1:0]         plane_reg;
    logic [LEN_BITS-1:0]   line_reg;
    logic [ADDR_BITS-1:0]  row_base_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic                  finished_reg;

    logic                  out_valid_reg;
    logic [7:0]            out_value_reg;
    logic [19:0]           out_addr_reg;
    logic                  out_in_image_reg;
    logic                  out_last_reg;
    logic                  out_done_reg;

    logic                  accept;
    logic                  out_free;
    logic [CW-1:0]         np_eff;
    logic [CW-1:0]         plane_inc;
    logic                  plane_wrap;
    logic [COLW-1:0]       col_inc;
    logic                  scan_end;
    logic [COLW-1:0]       line_inc;
    logic                  line_last;
    logic [ADDR_BITS-1:0]  add_a;
    logic [ADDR_BITS-1:0]  add_b;
    logic [ADDR_BITS-1:0]  add_sum;

    // Configuration registers
    assign cfg_ready = 1'b1;

    prpd_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Effective plane count: zero acts as one, clamp at MAX_PLANES
    always_comb
    begin
        priority if (cfg.num_planes == '0)
            np_eff = CW'(1);
        else if (32'(cfg.num_planes) > MAX_PLANES)
            np_eff = CW'(MAX_PLANES);
        else
            np_eff = CW'(cfg.num_planes);
    end

    // Scan position arithmetic
    assign col_inc    = col_reg + COLW'(1);
    assign scan_end   = col_inc >= {1'b0, cfg.bytes_per_line};
    assign plane_inc  = {1'b0, plane_reg} + CW'(1);
    assign plane_wrap = plane_inc >= np_eff;
    assign line_inc   = {1'b0, line_reg} + COLW'(1);
    assign line_last  = line_inc >= {1'b0, cfg.image_height};

    // Shared address adder: pixel step, row advance, scan start
    always_comb
    begin
        unique case (state_reg)
            S_ROW:
            begin
                add_a = row_base_reg;
                add_b = ADDR_BITS'(cfg.row_pitch);
            end
            S_ADDR:
            begin
                add_a = row_base_reg;
                add_b = ADDR_BITS'(plane_reg);
            end
            default:
            begin
                add_a = addr_reg;
                add_b = ADDR_BITS'(np_eff);
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    // Handshake
    assign byte_stall = (state_reg != S_IDLE);
    assign accept     = byte_valid & ~byte_stall;
    assign out_free   = ~out_valid_reg | ~pixel_stall;

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            run_pending_reg  <= 1'b0;
            run_length_reg   <= '0;
            remain_reg       <= '0;
            value_reg        <= '0;
            col_reg          <= '0;
            plane_reg        <= '0;
            line_reg         <= '0;
            row_base_reg     <= '0;
            addr_reg         <= '0;
            finished_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_value_reg    <= '0;
            out_addr_reg     <= '0;
            out_in_image_reg <= 1'b0;
            out_last_reg     <= 1'b0;
            out_done_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !pixel_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && !finished_reg)
                    begin
                        priority if (run_pending_reg)
                        begin
                            run_pending_reg <= 1'b0;
                            remain_reg      <= run_length_reg;
                            value_reg       <= data_byte;
                            if (run_length_reg != '0)
                            begin
                                state_reg <= S_EMIT;
                            end
                        end
                        else if ((data_byte & RUN_MARK) == RUN_MARK)
                        begin
                            run_length_reg  <= RUN_BITS'(data_byte & COUNT_MASK);
                            run_pending_reg <= 1'b1;
                        end
                        else
                        begin
                            remain_reg <= RUN_BITS'(1);
                            value_reg  <= data_byte;
                            state_reg  <= S_EMIT;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_value_reg    <= value_reg;
                        out_addr_reg     <= 20'(addr_reg);
                        out_in_image_reg <= col_reg < {1'b0, cfg.image_width};
                        out_last_reg     <= (remain_reg == RUN_BITS'(1));
                        out_done_reg     <= (remain_reg == RUN_BITS'(1)) && scan_end
                                            && plane_wrap && line_last;
                        col_reg          <= col_inc;
                        addr_reg         <= add_sum;
                        remain_reg       <= remain_reg - RUN_BITS'(1);
                        if (remain_reg == RUN_BITS'(1))
                        begin
                            state_reg <= scan_end ? S_ROW : S_IDLE;
                        end
                    end
                end

                S_ROW:
                begin
                    col_reg <= '0;
                    if (plane_wrap)
                    begin
                        plane_reg    <= '0;
                        line_reg     <= line_inc[LEN_BITS-1:0];
                        row_base_reg <= add_sum;
                        if (line_last)
                        begin
                            finished_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        plane_reg <= plane_inc[PW-1:0];
                    end
                    state_reg <= S_ADDR;
                end

                S_ADDR:
                begin
                    addr_reg  <= add_sum;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_value = out_value_reg;
    assign pixel_addr  = out_addr_reg;
    assign in_image    = out_in_image_reg;
    assign last_of_run = out_last_reg;
    assign image_done  = out_done_reg;

`ifndef SYNTH
    // The final pixel of an image always closes its input's run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && image_done |-> last_of_run)
        else $error("image_done without last_of_run");

    // Emission never starts with an empty run count
    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> remain_reg != '0)
        else $error("emitting with zero remaining count");

    // Plane index stays inside the supported plane range
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(plane_reg) < MAX_PLANES)
        else $error("plane index out of range");

    // Once finished, the sequencer never leaves idle again
    a_finished_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg && state_reg == S_IDLE |=> state_reg == S_IDLE)
        else $error("activity after image finished");
`endif

endmodule
